// File: design/cpc_pkg.sv
`default_nettype none

package cpc_pkg;

    // Coordinate width (signed Q12.4 at the default scaling).
    localparam int COORD_W  = 16;
    // Radius in coordinate units. The radius register has 8 bits, so 16 bits
    // hold it while the scaling shift is at most 8 bits.
    localparam int RAD_W    = 16;
    localparam int SQ_W     = 32;
    localparam int D2_W     = 34;
    localparam int ROOT_W   = 36;
    localparam int DIST_W   = 17;
    localparam int NUM_W    = 34;
    localparam int DIVR_W   = 18;
    localparam int SQ_CELLS  = 18;
    localparam int DIV_CELLS = 16;
    localparam int ADDR_W   = 4;

    typedef enum logic [1:0] {
        REG_CENTER_X = 2'd0,
        REG_CENTER_Y = 2'd1,
        REG_RADIUS   = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
    } point_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] out_x;
        logic signed [COORD_W-1:0] out_y;
        logic                      was_clamped;
    } result_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] px;
        logic signed [COORD_W-1:0] py;
        logic signed [COORD_W-1:0] cx;
        logic signed [COORD_W-1:0] cy;
        logic                      neg_x;
        logic                      neg_y;
        logic [COORD_W-1:0]        ax;
        logic [COORD_W-1:0]        ay;
        logic [RAD_W-1:0]          r;
        logic                      in_circle;
        logic [SQ_W-1:0]           sqx;
        logic [SQ_W-1:0]           sqy;
        logic [SQ_W-1:0]           rr;
        logic [D2_W-1:0]           rem_root;
        logic [ROOT_W-1:0]         root;
        logic [NUM_W-1:0]          numx;
        logic [NUM_W-1:0]          numy;
        logic [DIVR_W-1:0]         divr;
        logic [RAD_W-1:0]          qx;
        logic [RAD_W-1:0]          qy;
    } pipe_t;

endpackage

`default_nettype wire

// File: design/cpc_slot.sv
`default_nettype none

module cpc_slot (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    input  wire cpc_pkg::pipe_t in_data,
    output logic                in_ready,
    output logic                out_valid,
    output cpc_pkg::pipe_t      out_data,
    input  wire logic           out_ready
);
    import cpc_pkg::*;

    logic  valid_reg;
    pipe_t data_reg;

    // The slot takes new data when it is empty or its content moves on.
    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= in_data;
        end
    end

endmodule

`default_nettype wire

// File: design/cpc_sqrt_cell.sv
`default_nettype none

module cpc_sqrt_cell #(
    parameter int SHIFT = 0
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    input  wire cpc_pkg::pipe_t in_data,
    output logic                in_ready,
    output logic                out_valid,
    output cpc_pkg::pipe_t      out_data,
    input  wire logic           out_ready
);
    import cpc_pkg::*;

    logic [ROOT_W-1:0] bit_v;
    logic [ROOT_W-1:0] trial;
    pipe_t             nxt;

    // One digit of the restoring square root: try the bit at SHIFT.
    always_comb
    begin
        bit_v = ROOT_W'(1) << SHIFT;
        trial = in_data.root + bit_v;
        nxt   = in_data;
        if ({{(ROOT_W-D2_W){1'b0}}, in_data.rem_root} >= trial)
        begin
            nxt.rem_root = in_data.rem_root - trial[D2_W-1:0];
            nxt.root     = (in_data.root >> 1) + bit_v;
        end
        else
        begin
            nxt.root = in_data.root >> 1;
        end
    end

    cpc_slot u_slot (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_data   (nxt),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_data  (out_data),
        .out_ready (out_ready)
    );

endmodule

`default_nettype wire

// File: design/cpc_div_cell.sv
`default_nettype none

module cpc_div_cell #(
    parameter int SHIFT = 0
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    input  wire cpc_pkg::pipe_t in_data,
    output logic                in_ready,
    output logic                out_valid,
    output cpc_pkg::pipe_t      out_data,
    input  wire logic           out_ready
);
    import cpc_pkg::*;

    logic [NUM_W-1:0] cmp;
    pipe_t            nxt;

    // One quotient bit for each axis, both against the same divisor.
    always_comb
    begin
        cmp = NUM_W'(in_data.divr) << SHIFT;
        nxt = in_data;
        if (in_data.numx >= cmp)
        begin
            nxt.numx      = in_data.numx - cmp;
            nxt.qx[SHIFT] = 1'b1;
        end
        if (in_data.numy >= cmp)
        begin
            nxt.numy      = in_data.numy - cmp;
            nxt.qy[SHIFT] = 1'b1;
        end
    end

    cpc_slot u_slot (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_data   (nxt),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_data  (out_data),
        .out_ready (out_ready)
    );

endmodule

`default_nettype wire

// File: design/clamp_point_to_circle.sv
// Clamps each point into a circle set by the center and radius registers.
// A point within the circle comes out unchanged with was_clamped low; any
// other point is moved onto the circle along the ray from the center and
// comes out with was_clamped high, each coordinate rounded to nearest and
// saturated. The block takes one point in every cycle while the output is
// not stalled; each result passes through a chain of 18 square root cells
// and 16 divider cells plus six arithmetic and output stages. Every stage
// is a slot that fills whenever it is empty, so a stalled output only holds
// back points once the stages behind it are full. Registers: center_x at
// byte address 0, center_y at 4, circle_radius (whole pixels) at 8. Write
// them only while no point is in flight.
`default_nettype none

module clamp_point_to_circle #(
    parameter int FRAC_BITS = 4
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       point_valid,
    output logic                            point_stall,
    input  wire cpc_pkg::point_t            point,
    output logic                            result_valid,
    input  wire logic                       result_stall,
    output cpc_pkg::result_t                result,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [cpc_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]                pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);
    import cpc_pkg::*;

    // Configuration registers.
    logic signed [COORD_W-1:0] cx_reg;
    logic signed [COORD_W-1:0] cy_reg;
    logic [7:0]                radius_reg;
    logic                      wr_en;
    reg_idx_t                  wr_idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign wr_idx = reg_idx_t'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cx_reg     <= '0;
            cy_reg     <= '0;
            radius_reg <= 8'd50;
        end
        else if (wr_en)
        begin
            unique case (wr_idx)
                REG_CENTER_X: cx_reg     <= pwdata[COORD_W-1:0];
                REG_CENTER_Y: cy_reg     <= pwdata[COORD_W-1:0];
                REG_RADIUS:   radius_reg <= pwdata[7:0];
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        unique case (wr_idx)
            REG_CENTER_X: prdata = {16'd0, cx_reg};
            REG_CENTER_Y: prdata = {16'd0, cy_reg};
            REG_RADIUS:   prdata = {24'd0, radius_reg};
            default:      prdata = '0;
        endcase
    end

    // Front stage: offsets from the center and their magnitudes.
    logic signed [COORD_W:0] dx;
    logic signed [COORD_W:0] dy;
    logic [COORD_W:0]        ndx;
    logic [COORD_W:0]        ndy;
    pipe_t                   front_d;

    always_comb
    begin
        dx  = {point.point_x[COORD_W-1], point.point_x} - {cx_reg[COORD_W-1], cx_reg};
        dy  = {point.point_y[COORD_W-1], point.point_y} - {cy_reg[COORD_W-1], cy_reg};
        ndx = -dx;
        ndy = -dy;
        front_d       = '0;
        front_d.px    = point.point_x;
        front_d.py    = point.point_y;
        front_d.cx    = cx_reg;
        front_d.cy    = cy_reg;
        front_d.neg_x = dx[COORD_W];
        front_d.neg_y = dy[COORD_W];
        front_d.ax    = dx[COORD_W] ? ndx[COORD_W-1:0] : dx[COORD_W-1:0];
        front_d.ay    = dy[COORD_W] ? ndy[COORD_W-1:0] : dy[COORD_W-1:0];
        front_d.r     = RAD_W'({8'd0, radius_reg} << FRAC_BITS);
    end

    logic  s0_valid, s0_ready, s1_valid, s1_ready, s2_valid, s2_ready;
    pipe_t s0_q, s1_d, s1_q, s2_d, s2_q;
    logic  in_ready;

    assign point_stall = !in_ready;

    cpc_slot u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(point_valid), .in_data(front_d), .in_ready(in_ready),
        .out_valid(s0_valid), .out_data(s0_q), .out_ready(s0_ready)
    );

    // Squares of both offsets and of the radius.
    always_comb
    begin
        s1_d     = s0_q;
        s1_d.sqx = s0_q.ax * s0_q.ax;
        s1_d.sqy = s0_q.ay * s0_q.ay;
        s1_d.rr  = SQ_W'(s0_q.r) * SQ_W'(s0_q.r);
    end

    cpc_slot u_square (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s0_valid), .in_data(s1_d), .in_ready(s0_ready),
        .out_valid(s1_valid), .out_data(s1_q), .out_ready(s1_ready)
    );

    // Squared distance, the inside test, and the square root seed.
    logic [D2_W-1:0] d2;

    always_comb
    begin
        d2          = {2'b00, s1_q.sqx} + {2'b00, s1_q.sqy};
        s2_d        = s1_q;
        s2_d.in_circle = d2 <= {2'b00, s1_q.rr};
        s2_d.rem_root = d2;
        s2_d.root   = '0;
    end

    cpc_slot u_sum (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s1_valid), .in_data(s2_d), .in_ready(s1_ready),
        .out_valid(s2_valid), .out_data(s2_q), .out_ready(s2_ready)
    );

    // Square root chain: cell k resolves the bit pair at 2*(SQ_CELLS-1-k).
    logic  sq_valid [0:SQ_CELLS];
    logic  sq_ready [0:SQ_CELLS];
    pipe_t sq_data  [0:SQ_CELLS];

    assign sq_valid[0] = s2_valid;
    assign sq_data[0]  = s2_q;
    assign s2_ready    = sq_ready[0];

    for (genvar k = 0; k < SQ_CELLS; k++)
    begin : g_sqrt
        cpc_sqrt_cell #(.SHIFT(2 * (SQ_CELLS - 1 - k))) u_cell (
            .clk(clk), .rst_n(rst_n),
            .in_valid(sq_valid[k]), .in_data(sq_data[k]), .in_ready(sq_ready[k]),
            .out_valid(sq_valid[k+1]), .out_data(sq_data[k+1]),
            .out_ready(sq_ready[k+1])
        );
    end

    // Offset magnitudes times the radius.
    logic  s3_valid, s3_ready, s4_valid;
    pipe_t s3_d, s3_q, s4_d, s4_q;

    always_comb
    begin
        s3_d      = sq_data[SQ_CELLS];
        s3_d.numx = NUM_W'(sq_data[SQ_CELLS].ax * sq_data[SQ_CELLS].r);
        s3_d.numy = NUM_W'(sq_data[SQ_CELLS].ay * sq_data[SQ_CELLS].r);
    end

    cpc_slot u_mult (
        .clk(clk), .rst_n(rst_n),
        .in_valid(sq_valid[SQ_CELLS]), .in_data(s3_d), .in_ready(sq_ready[SQ_CELLS]),
        .out_valid(s3_valid), .out_data(s3_q), .out_ready(s3_ready)
    );

    // Rounding: quotient of (2*m*R + D) by 2*D.
    logic [DIST_W-1:0] root_dist;

    always_comb
    begin
        root_dist = s3_q.root[DIST_W-1:0];
        s4_d      = s3_q;
        s4_d.numx = {s3_q.numx[NUM_W-2:0], 1'b0} + NUM_W'(root_dist);
        s4_d.numy = {s3_q.numy[NUM_W-2:0], 1'b0} + NUM_W'(root_dist);
        s4_d.divr = {root_dist, 1'b0};
        s4_d.qx   = '0;
        s4_d.qy   = '0;
    end

    logic  dv_valid [0:DIV_CELLS];
    logic  dv_ready [0:DIV_CELLS];
    pipe_t dv_data  [0:DIV_CELLS];

    cpc_slot u_prep (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s3_valid), .in_data(s4_d), .in_ready(s3_ready),
        .out_valid(s4_valid), .out_data(s4_q), .out_ready(dv_ready[0])
    );

    assign dv_valid[0] = s4_valid;
    assign dv_data[0]  = s4_q;

    // Divider chain: cell k yields quotient bit DIV_CELLS-1-k on both axes.
    for (genvar k = 0; k < DIV_CELLS; k++)
    begin : g_div
        cpc_div_cell #(.SHIFT(DIV_CELLS - 1 - k)) u_cell (
            .clk(clk), .rst_n(rst_n),
            .in_valid(dv_valid[k]), .in_data(dv_data[k]), .in_ready(dv_ready[k]),
            .out_valid(dv_valid[k+1]), .out_data(dv_data[k+1]),
            .out_ready(dv_ready[k+1])
        );
    end

    // Output stage: apply sign, add center, saturate.
    logic              result_valid_reg;
    result_t           result_reg;
    result_t           result_next;
    logic              last_ready;
    pipe_t             fin;
    logic [COORD_W:0]  qsx, qsy;
    logic [COORD_W+1:0] sumx, sumy;

    function automatic logic [COORD_W-1:0] sat(input logic [COORD_W+1:0] v);
        logic [COORD_W-1:0] o;
        if (v[COORD_W+1] && !(v[COORD_W] && v[COORD_W-1]))
        begin
            o = {1'b1, {(COORD_W-1){1'b0}}};
        end
        else if (!v[COORD_W+1] && (v[COORD_W] || v[COORD_W-1]))
        begin
            o = {1'b0, {(COORD_W-1){1'b1}}};
        end
        else
        begin
            o = v[COORD_W-1:0];
        end
        return o;
    endfunction

    always_comb
    begin
        fin  = dv_data[DIV_CELLS];
        qsx  = fin.neg_x ? -{1'b0, fin.qx} : {1'b0, fin.qx};
        qsy  = fin.neg_y ? -{1'b0, fin.qy} : {1'b0, fin.qy};
        sumx = {{2{fin.cx[COORD_W-1]}}, fin.cx} + {qsx[COORD_W], qsx};
        sumy = {{2{fin.cy[COORD_W-1]}}, fin.cy} + {qsy[COORD_W], qsy};
        if (fin.in_circle)
        begin
            result_next.out_x       = fin.px;
            result_next.out_y       = fin.py;
            result_next.was_clamped = 1'b0;
        end
        else
        begin
            result_next.out_x       = sat(sumx);
            result_next.out_y       = sat(sumy);
            result_next.was_clamped = 1'b1;
        end
    end

    assign last_ready          = !result_valid_reg || !result_stall;
    assign dv_ready[DIV_CELLS] = last_ready;
    assign result_valid        = result_valid_reg;
    assign result              = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (last_ready)
        begin
            result_valid_reg <= dv_valid[DIV_CELLS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (last_ready && dv_valid[DIV_CELLS])
        begin
            result_reg <= result_next;
        end
    end

endmodule

`default_nettype wire

// File: design/cpc_checker.sv
`default_nettype none

module cpc_checker (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              point_valid,
    input  wire logic              point_stall,
    input  wire logic              result_valid,
    input  wire logic              result_stall,
    input  wire cpc_pkg::result_t  result,
    input  wire logic              pready
);
    import cpc_pkg::*;

    localparam int DEPTH = 40;

    logic [6:0] inflight_reg;
    logic [6:0] inflight_next;
    logic       in_xfer;
    logic       out_xfer;

    assign in_xfer  = point_valid && !point_stall;
    assign out_xfer = result_valid && !result_stall;

    always_comb
    begin
        inflight_next = inflight_reg + 7'(in_xfer) - 7'(out_xfer);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inflight_reg <= '0;
        end
        else
        begin
            inflight_reg <= inflight_next;
        end
    end

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> inflight_reg != 7'd0)
        else $error("result shown with no point in flight");

    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        inflight_reg <= 7'(DEPTH))
        else $error("more points in flight than pipeline slots");

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid)
        else $error("stalled result dropped");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> $stable(result))
        else $error("stalled result changed");

    a_pready: assert property (@(posedge clk) disable iff (!rst_n)
        pready)
        else $error("configuration port not ready");

endmodule

bind clamp_point_to_circle cpc_checker u_cpc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .point_valid  (point_valid),
    .point_stall  (point_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .pready       (pready)
);

`default_nettype wire

// File: verif/testbench.sv
module testbench;
    import cpc_pkg::*;

    // The block has no state between points, so the checker only needs the
    // current register values to predict each transfer's result.
    localparam int FRAC_BITS   = 4;
    localparam int LATENCY     = 40;
    localparam int IDLE_LIMIT  = 5000;
    localparam int RANDOM_ITEMS = 800;

    logic clk;
    logic rst_n;
    logic point_valid;
    logic point_stall;
    point_t point;
    logic result_valid;
    logic result_stall;
    result_t result;
    logic psel;
    logic penable;
    logic pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;

    clamp_point_to_circle #(.FRAC_BITS(FRAC_BITS)) DUT (
        .clk(clk), .rst_n(rst_n),
        .point_valid(point_valid), .point_stall(point_stall), .point(point),
        .result_valid(result_valid), .result_stall(result_stall), .result(result),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Shadow copy of the configuration registers.
    logic signed [15:0] circ_cx;
    logic signed [15:0] circ_cy;
    logic [7:0]         circ_radius;

    // Expected results, oldest first.
    result_t clamped_queue[$];

    int  error_count;
    int  idle_cycles;
    bit  stimulus_done;

    typedef struct {
        logic signed [15:0] px;
        logic signed [15:0] py;
        bit                 known;
        result_t            answer;
    } vector_t;

    function automatic logic [63:0] int_sqrt(input logic [63:0] v);
        logic [63:0] root;
        logic [63:0] bitv;
        logic [63:0] rem;
        root = 0;
        rem = v;
        bitv = 64'd1 << 40;
        while (bitv > rem)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (rem >= root + bitv)
            begin
                rem = rem - (root + bitv);
                root = (root >> 1) + bitv;
            end
            else
            begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    function automatic longint scale_offset(input longint d, input longint r,
                                            input longint root_dist);
        longint mag;
        longint q;
        mag = (d < 0) ? -d : d;
        q = (2 * mag * r + root_dist) / (2 * root_dist);
        return (d < 0) ? -q : q;
    endfunction

    function automatic logic [15:0] saturate16(input longint v);
        if (v > 32767)
            return 16'sh7fff;
        if (v < -32768)
            return 16'sh8000;
        return v[15:0];
    endfunction

    // Projects a point onto the circle when it lies outside it.
    function automatic result_t clamp_point(input logic signed [15:0] px,
                                            input logic signed [15:0] py);
        result_t res;
        longint dx;
        longint dy;
        longint d2;
        longint r;
        longint root_dist;
        dx = longint'(px) - longint'(circ_cx);
        dy = longint'(py) - longint'(circ_cy);
        d2 = dx * dx + dy * dy;
        r = longint'(circ_radius) << FRAC_BITS;
        if (d2 <= r * r)
        begin
            res.out_x = px;
            res.out_y = py;
            res.was_clamped = 1'b0;
        end
        else
        begin
            root_dist = longint'(int_sqrt(d2));
            if (root_dist == 0)
                root_dist = 1;
            res.out_x = saturate16(longint'(circ_cx) + scale_offset(dx, r, root_dist));
            res.out_y = saturate16(longint'(circ_cy) + scale_offset(dy, r, root_dist));
            res.was_clamped = 1'b1;
        end
        return res;
    endfunction

    // Writes one register through the setup and access phases of the port.
    // The port stays selected afterwards; the caller releases it.
    task automatic write_register(input reg_idx_t idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(idx) << 2;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        case (idx)
            REG_CENTER_X: circ_cx = value[15:0];
            REG_CENTER_Y: circ_cy = value[15:0];
            REG_RADIUS:   circ_radius = value[7:0];
            default: ;
        endcase
    endtask

    task automatic configure(input logic [15:0] cx, input logic [15:0] cy,
                             input logic [7:0] radius);
        write_register(REG_CENTER_X, {16'd0, cx});
        write_register(REG_CENTER_Y, {16'd0, cy});
        write_register(REG_RADIUS, {24'd0, radius});
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Waits until every expected result has come back, plus a tail for the
    // pipeline to settle before the registers may change.
    task automatic drain_pipeline();
        while (clamped_queue.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    // Presents one point after a random gap and holds it until accepted.
    task automatic send_point(input logic signed [15:0] px,
                              input logic signed [15:0] py,
                              input bit known, input result_t answer);
        int gap;
        result_t predicted;
        gap = (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18));
        if ($urandom_range(0, 9) < 4)
            gap = 0;
        if (gap != 0)
        begin
            point_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        point_valid   <= 1'b1;
        point.point_x <= px;
        point.point_y <= py;
        @(posedge clk);
        while (point_stall)
            @(posedge clk);
        predicted = clamp_point(px, py);
        if (known && predicted != answer)
        begin
            $error("table row disagrees with prediction for %0d,%0d", px, py);
            error_count = error_count + 1;
        end
        clamped_queue.push_back(known ? answer : predicted);
    endtask

    task automatic finish_sending();
        point_valid <= 1'b0;
    endtask

    // Receiver: stalls for a random number of cycles between transfers,
    // with occasional stretches of no stalling at all.
    int stall_left;
    int burst_left;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_stall <= 1'b0;
            stall_left = 0;
            burst_left = 0;
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                if (burst_left > 0)
                begin
                    burst_left = burst_left - 1;
                    stall_left = 0;
                end
                else if ($urandom_range(0, 19) == 0)
                begin
                    burst_left = $urandom_range(10, 60);
                    stall_left = 0;
                end
                else
                begin
                    stall_left = $urandom_range(0, 18);
                end
            end
            else if (stall_left > 0)
            begin
                stall_left = stall_left - 1;
            end
            result_stall <= (stall_left > 0);
        end
    end

    // Result checker: every transfer on the output is compared, field by
    // field, with the oldest outstanding expectation.
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            if (clamped_queue.size() == 0)
            begin
                $error("result with no point outstanding: %0d,%0d",
                       result.out_x, result.out_y);
                error_count = error_count + 1;
            end
            else
            begin
                result_t want;
                want = clamped_queue.pop_front();
                if (result.out_x !== want.out_x)
                begin
                    $error("out_x expected %0d actual %0d", want.out_x, result.out_x);
                    error_count = error_count + 1;
                end
                if (result.out_y !== want.out_y)
                begin
                    $error("out_y expected %0d actual %0d", want.out_y, result.out_y);
                    error_count = error_count + 1;
                end
                if (result.was_clamped !== want.was_clamped)
                begin
                    $error("was_clamped expected %0b actual %0b",
                           want.was_clamped, result.was_clamped);
                    error_count = error_count + 1;
                end
            end
        end
    end

    // Watchdog: ends the run when no transfer happens for too long.
    always @(posedge clk)
    begin
        if ((point_valid && !point_stall) || (result_valid && !result_stall)
            || stimulus_done || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic result_t make_result(input logic [15:0] x,
                                            input logic [15:0] y, input bit c);
        result_t res;
        res.out_x = x;
        res.out_y = y;
        res.was_clamped = c;
        return res;
    endfunction

    vector_t directed[$];

    task automatic add_row(input logic [15:0] px, input logic [15:0] py,
                           input bit known, input result_t answer);
        vector_t v;
        v.px = px;
        v.py = py;
        v.known = known;
        v.answer = answer;
        directed.push_back(v);
    endtask

    // Random point: mostly near the circle so both sides of the boundary are
    // exercised, sometimes anywhere in the full coordinate range.
    task automatic random_point(output logic signed [15:0] px,
                                output logic signed [15:0] py);
        int span;
        if ($urandom_range(0, 3) == 0)
        begin
            px = 16'($urandom());
            py = 16'($urandom());
        end
        else
        begin
            span = (int'(circ_radius) << FRAC_BITS) + 64;
            px = saturate16(longint'(circ_cx) + $urandom_range(0, 2 * span) - span);
            py = saturate16(longint'(circ_cy) + $urandom_range(0, 2 * span) - span);
        end
    endtask

    initial
    begin
        logic signed [15:0] px;
        logic signed [15:0] py;
        result_t none;
        none = '0;
        error_count = 0;
        stimulus_done = 1'b0;
        rst_n = 1'b0;
        point_valid = 1'b0;
        point = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        circ_cx = 16'sd0;
        circ_cy = 16'sd0;
        circ_radius = 8'd50;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table at reset values: center 0,0 and radius 50 pixels,
        // that is 800 in coordinate units.
        add_row(16'sd0, 16'sd0, 1, make_result(16'sd0, 16'sd0, 0));
        add_row(16'sd800, 16'sd0, 1, make_result(16'sd800, 16'sd0, 0));
        add_row(16'sd801, 16'sd0, 1, make_result(16'sd800, 16'sd0, 1));
        add_row(16'sh7fff, 16'sd0, 1, make_result(16'sd800, 16'sd0, 1));
        add_row(16'sh8000, 16'sd0, 1, make_result(-16'sd800, 16'sd0, 1));
        add_row(16'sd0, 16'sh8000, 1, make_result(16'sd0, -16'sd800, 1));
        add_row(16'sh7fff, 16'sh7fff, 0, none);
        add_row(16'sh8000, 16'sh8000, 0, none);
        add_row(16'sh8000, 16'sh7fff, 0, none);
        add_row(-16'sd565, 16'sd566, 0, none);
        add_row(16'sd3000, -16'sd4000, 1, make_result(16'sd480, -16'sd640, 1));
        foreach (directed[i])
            send_point(directed[i].px, directed[i].py, directed[i].known,
                       directed[i].answer);
        finish_sending();
        drain_pipeline();

        // Zero radius: every point other than the center collapses onto it.
        configure(16'sd100, -16'sd100, 8'd0);
        send_point(16'sd100, -16'sd100, 1, make_result(16'sd100, -16'sd100, 0));
        send_point(16'sd101, -16'sd100, 1, make_result(16'sd100, -16'sd100, 1));
        send_point(16'sh8000, 16'sh7fff, 1, make_result(16'sd100, -16'sd100, 1));
        finish_sending();
        drain_pipeline();

        // Extreme center and largest radius: the offsets reach the full span of
        // the coordinate range.
        configure(16'sh7fff, 16'sh8000, 8'd255);
        send_point(16'sh8000, 16'sh7fff, 0, none);
        send_point(16'sh7fff, 16'sh7fff, 1, make_result(16'sh7fff, -16'sd28688, 1));
        send_point(16'sd0, 16'sd0, 0, none);
        finish_sending();
        drain_pipeline();

        // Random phases, each under a fresh register setting. Most use random
        // values over the full range; three extreme settings get one phase each.
        for (int phase = 0; phase < 8; phase++)
        begin
            case (phase)
                0: configure(16'sh8000, 16'sh7fff, 8'd255);
                1: configure(16'sd0, 16'sd0, 8'd1);
                2: configure(16'sh7fff, 16'sh7fff, 8'd0);
                default: configure(16'($urandom()), 16'($urandom()), 8'($urandom()));
            endcase
            for (int n = 0; n < RANDOM_ITEMS / 8; n++)
            begin
                random_point(px, py);
                send_point(px, py, 0, none);
            end
            finish_sending();
            // Hold the sender off until everything has come back.
            drain_pipeline();
        end

        stimulus_done = 1'b1;
        repeat (LATENCY * 4) @(posedge clk);
        if (error_count == 0 && clamped_queue.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
